>>> rtl/first_fit_range_allocator_macros.svh
// Assertion macros for the first-fit range allocator.
// Used by the top level; needs a clock named clk and a reset named rst_n in scope.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FFRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFRA_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FFRA_ASSERT(label, prop, msg)
`define FFRA_NEVER(label, expr, msg)
`endif
`endif

>>> rtl/ffra_pkg.sv
// Shared types and constants of the first-fit range allocator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package ffra_pkg;
    localparam int SLOT_BITS = 20;
    localparam int MAX_EXTENTS_DEF = 32;
    localparam int OFF_W = 20;
    localparam int CNT_W = 21;
    localparam int SUM_W = 22;
    localparam logic [SUM_W-1:0] SLOT_LIMIT = SUM_W'(1) << SLOT_BITS;
    localparam logic [CNT_W-1:0] TARGET_RESET = 21'd1024;
    localparam logic [CNT_W-1:0] VIEW_RESET = 21'd65536;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_VIEW = 2'd1;

    typedef enum logic [2:0] {
        ST_OK, ST_NOFIT, ST_DOUBLE, ST_FULL, ST_ZERO
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_READ, S_CHECK, S_ALLOC_WR, S_DN_RD, S_DN_WR,
        S_DECIDE, S_UP_CHK, S_UP_WR, S_RESP
    } state_t;

    typedef enum logic [1:0] {RD_IDX, RD_NEXT, RD_PREV} rd_sel_t;

    typedef enum logic [2:0] {
        WR_ALLOC, WR_BOTH, WR_LEFT, WR_RIGHT, WR_NEW, WR_MOVE
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd;
        rd_sel_t rd_sel;
        logic    wr;
        wr_sel_t wr_sel;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_load_n;
        logic    save_left;
        logic    save_pos;
        logic    n_inc;
        logic    n_dec;
        logic    set_status;
        status_t status;
        logic    grant;
        logic    resp;
    } cmd_t;

    typedef struct packed {
        logic zero_cnt;
        logic is_free;
        logic too_far;
        logic n_zero;
        logic idx_last;
        logic fit;
        logic start_le_off;
        logic overlap;
        logic join_l;
        logic join_r;
        logic newlen_zero;
        logic dn_more;
        logic full;
        logic up_more;
        logic out_busy;
    } sts_t;
endpackage
`default_nettype wire

>>> rtl/ffra_datapath.sv
// Datapath of the allocator: extent memory, counts, request and result registers.
// Depends on ffra_pkg; driven by ffra_controller through cmd_t.
`default_nettype none
module ffra_datapath #(
    parameter int MAX_EXTENTS = ffra_pkg::MAX_EXTENTS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_addr,
    input  wire logic [ffra_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                        func,
    input  wire logic                        heap,
    input  wire logic [ffra_pkg::OFF_W-1:0]  range_offset,
    input  wire logic [ffra_pkg::CNT_W-1:0]  range_count,
    input  wire logic                        out_ready,
    input  wire ffra_pkg::cmd_t              cmd,
    output ffra_pkg::sts_t                   sts,
    output logic                             out_valid,
    output logic [2:0]                       status,
    output logic [ffra_pkg::OFF_W-1:0]       granted_offset,
    output logic [ffra_pkg::CNT_W-1:0]       granted_count
);
    import ffra_pkg::*;

    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int ENT_W = OFF_W + CNT_W;
    localparam int DEPTH = 2 * (2 ** AW);
    localparam logic [CW-1:0] MAX_N = CW'(MAX_EXTENTS);

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] mem_q;

    logic             func_reg, heap_reg;
    logic [OFF_W-1:0] off_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CW-1:0]    idx_reg, idx_next, pos_reg;
    logic [CW-1:0]    n_reg [2];
    logic [1:0]       init_reg;
    logic [CNT_W-1:0] size_reg [2];
    logic             rd_init_reg;
    logic [CNT_W-1:0] rd_size_reg;
    logic [OFF_W-1:0] lstart_reg;
    logic [CNT_W-1:0] llen_reg;
    status_t          status_reg;
    logic [OFF_W-1:0] grant_off_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [OFF_W-1:0] out_off_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic [CW-1:0]    n_cur, idx_p1, idx_m1, raddr_idx, waddr_idx;
    logic [OFF_W-1:0] rd_start;
    logic [CNT_W-1:0] rd_len, newlen, wlen;
    logic [OFF_W-1:0] wstart;
    logic [SUM_W-1:0] off_end, lend;

    // Current heap's count and index neighbors.
    assign n_cur  = n_reg[heap_reg];
    assign idx_p1 = idx_reg + CW'(1);
    assign idx_m1 = idx_reg - CW'(1);

    // Read data; entry zero of a freshly sized heap reads as the whole heap.
    assign rd_start = rd_init_reg ? '0 : mem_q[ENT_W-1:CNT_W];
    assign rd_len   = rd_init_reg ? rd_size_reg : mem_q[CNT_W-1:0];
    assign newlen   = rd_len - cnt_reg;
    assign off_end  = {2'b00, off_reg} + {1'b0, cnt_reg};
    assign lend     = {2'b00, lstart_reg} + {1'b0, llen_reg};

    // Status toward the controller.
    always_comb
    begin
        sts.zero_cnt     = (cnt_reg == '0);
        sts.is_free      = func_reg;
        sts.too_far      = (off_end > SLOT_LIMIT);
        sts.n_zero       = (n_cur == '0);
        sts.idx_last     = (idx_p1 == n_cur);
        sts.fit          = (rd_len >= cnt_reg);
        sts.start_le_off = (rd_start <= off_reg);
        sts.overlap      = ((idx_reg != '0) && (lend > {2'b00, off_reg}))
                        || ((idx_reg < n_cur) && (off_end > {2'b00, rd_start}));
        sts.join_l       = (idx_reg != '0) && (lend == {2'b00, off_reg});
        sts.join_r       = (idx_reg < n_cur) && (off_end == {2'b00, rd_start});
        sts.newlen_zero  = (newlen == '0);
        sts.dn_more      = (idx_p1 < n_cur);
        sts.full         = (n_cur == MAX_N);
        sts.up_more      = (idx_reg > pos_reg);
        sts.out_busy     = out_valid_reg && !out_ready;
    end

    // Addresses and write data.
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_NEXT: raddr_idx = idx_p1;
            RD_PREV: raddr_idx = idx_m1;
            default: raddr_idx = idx_reg;
        endcase
        waddr_idx = ((cmd.wr_sel == WR_BOTH) || (cmd.wr_sel == WR_LEFT)) ? idx_m1 : idx_reg;
        unique case (cmd.wr_sel)
            WR_ALLOC:
            begin
                wstart = rd_start + cnt_reg[OFF_W-1:0];
                wlen   = newlen;
            end
            WR_BOTH:
            begin
                wstart = lstart_reg;
                wlen   = llen_reg + cnt_reg + rd_len;
            end
            WR_LEFT:
            begin
                wstart = lstart_reg;
                wlen   = llen_reg + cnt_reg;
            end
            WR_RIGHT:
            begin
                wstart = off_reg;
                wlen   = rd_len + cnt_reg;
            end
            WR_NEW:
            begin
                wstart = off_reg;
                wlen   = cnt_reg;
            end
            default:
            begin
                wstart = rd_start;
                wlen   = rd_len;
            end
        endcase
    end

    // Extent memory with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[{heap_reg, waddr_idx[AW-1:0]}] <= {wstart, wlen};
        end
        if (cmd.rd)
        begin
            mem_q       <= mem[{heap_reg, raddr_idx[AW-1:0]}];
            rd_init_reg <= init_reg[heap_reg] && (raddr_idx == '0);
            rd_size_reg <= size_reg[heap_reg][CNT_W-1] ? SLOT_LIMIT[CNT_W-1:0]
                                                      : size_reg[heap_reg];
        end
    end

    // Request, left neighbor and grant registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            heap_reg <= heap;
            off_reg  <= range_offset;
            cnt_reg  <= range_count;
        end
        if (cmd.save_left)
        begin
            lstart_reg <= rd_start;
            llen_reg   <= rd_len;
        end
        if (cmd.save_pos)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.grant)
        begin
            grant_off_reg <= rd_start;
        end
    end

    // Scan index.
    always_comb
    begin
        priority if (cmd.load)
            idx_next = '0;
        else if (cmd.idx_load_n)
            idx_next = n_cur;
        else if (cmd.idx_inc)
            idx_next = idx_p1;
        else if (cmd.idx_dec)
            idx_next = idx_m1;
        else
            idx_next = idx_reg;
    end

    // Control state: index, counts, sizes, entry-zero flags, result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            n_reg[0]       <= CW'(1);
            n_reg[1]       <= CW'(1);
            init_reg       <= 2'b11;
            size_reg[0]    <= TARGET_RESET;
            size_reg[1]    <= VIEW_RESET;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_off_reg    <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.n_inc)
            begin
                n_reg[heap_reg] <= n_cur + CW'(1);
            end
            else if (cmd.n_dec)
            begin
                n_reg[heap_reg] <= n_cur - CW'(1);
            end
            if (cmd.wr && (waddr_idx == '0))
            begin
                init_reg[heap_reg] <= 1'b0;
            end
            if (cfg_wr_en && ((cfg_addr == CFG_TARGET) || (cfg_addr == CFG_VIEW)))
            begin
                size_reg[cfg_addr[0]] <= cfg_wdata;
                init_reg[cfg_addr[0]] <= 1'b1;
                n_reg[cfg_addr[0]]    <= (cfg_wdata != '0) ? CW'(1) : '0;
            end
            if (cmd.resp)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= status_reg;
                if (!func_reg && (status_reg == ST_OK))
                begin
                    out_off_reg <= grant_off_reg;
                    out_cnt_reg <= cnt_reg;
                end
                else
                begin
                    out_off_reg <= '0;
                    out_cnt_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_offset = out_off_reg;
    assign granted_count  = out_cnt_reg;
endmodule
`default_nettype wire

>>> rtl/ffra_controller.sv
// Controller of the allocator: sequences scans, shifts and writes.
// Depends on ffra_pkg; drives ffra_datapath through cmd_t and reads sts_t.
`default_nettype none
module ffra_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ffra_pkg::sts_t sts,
    output ffra_pkg::cmd_t      cmd
);
    import ffra_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid) state_next = S_START;
            S_START:
            begin
                priority if (sts.zero_cnt || (sts.is_free && sts.too_far))
                    state_next = S_RESP;
                else if (!sts.n_zero)
                    state_next = S_READ;
                else if (sts.is_free)
                    state_next = S_DECIDE;
                else
                    state_next = S_RESP;
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (!sts.is_free)
                begin
                    priority if (sts.fit)
                        state_next = S_ALLOC_WR;
                    else if (sts.idx_last)
                        state_next = S_RESP;
                    else
                        state_next = S_READ;
                end
                else
                begin
                    priority if (sts.start_le_off && !sts.idx_last)
                        state_next = S_READ;
                    else
                        state_next = S_DECIDE;
                end
            end
            S_ALLOC_WR:
                state_next = sts.newlen_zero ? S_DN_RD : S_RESP;
            S_DN_RD:
                state_next = sts.dn_more ? S_DN_WR : S_RESP;
            S_DN_WR:
                state_next = S_DN_RD;
            S_DECIDE:
            begin
                priority if (sts.overlap)
                    state_next = S_RESP;
                else if (sts.join_l && sts.join_r)
                    state_next = S_DN_RD;
                else if (sts.join_l || sts.join_r || sts.full)
                    state_next = S_RESP;
                else
                    state_next = S_UP_CHK;
            end
            S_UP_CHK:
                state_next = sts.up_more ? S_UP_WR : S_RESP;
            S_UP_WR:
                state_next = S_UP_CHK;
            S_RESP:
                if (!sts.out_busy) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        cmd.wr_sel = WR_MOVE;
        cmd.status = ST_OK;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_START:
            begin
                cmd.set_status = 1'b1;
                priority if (sts.zero_cnt)
                    cmd.status = ST_ZERO;
                else if (sts.is_free && sts.too_far)
                    cmd.status = ST_DOUBLE;
                else if (sts.n_zero && !sts.is_free)
                    cmd.status = ST_NOFIT;
                else
                    cmd.status = ST_OK;
            end
            S_READ:
                cmd.rd = 1'b1;
            S_CHECK:
            begin
                if (!sts.is_free)
                begin
                    if (!sts.fit)
                    begin
                        cmd.idx_inc    = 1'b1;
                        cmd.set_status = sts.idx_last;
                        cmd.status     = ST_NOFIT;
                    end
                end
                else if (sts.start_le_off)
                begin
                    cmd.save_left = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
            end
            S_ALLOC_WR:
            begin
                cmd.grant  = 1'b1;
                cmd.wr     = !sts.newlen_zero;
                cmd.wr_sel = WR_ALLOC;
            end
            S_DN_RD:
            begin
                cmd.rd     = sts.dn_more;
                cmd.rd_sel = RD_NEXT;
                cmd.n_dec  = !sts.dn_more;
            end
            S_DN_WR:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_sel  = WR_MOVE;
                cmd.idx_inc = 1'b1;
            end
            S_DECIDE:
            begin
                cmd.save_pos = 1'b1;
                priority if (sts.overlap)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DOUBLE;
                end
                else if (sts.join_l && sts.join_r)
                begin
                    cmd.wr     = 1'b1;
                    cmd.wr_sel = WR_BOTH;
                end
                else if (sts.join_l)
                begin
                    cmd.wr     = 1'b1;
                    cmd.wr_sel = WR_LEFT;
                end
                else if (sts.join_r)
                begin
                    cmd.wr     = 1'b1;
                    cmd.wr_sel = WR_RIGHT;
                end
                else if (sts.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                end
                else
                    cmd.idx_load_n = 1'b1;
            end
            S_UP_CHK:
            begin
                if (sts.up_more)
                begin
                    cmd.rd     = 1'b1;
                    cmd.rd_sel = RD_PREV;
                end
                else
                begin
                    cmd.wr     = 1'b1;
                    cmd.wr_sel = WR_NEW;
                    cmd.n_inc  = 1'b1;
                end
            end
            S_UP_WR:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_sel  = WR_MOVE;
                cmd.idx_dec = 1'b1;
            end
            S_RESP:
                cmd.resp = !sts.out_busy;
            default:
                cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/first_fit_range_allocator.sv
// First-fit range allocator with coalescing, top level.
// Depends on ffra_pkg, ffra_controller, ffra_datapath and the assertion macro header.
//
// Two heaps each keep a sorted table of free extents in one single-port extent memory
// with a registered read. One item is worked on at a time. An allocate reads entries
// in order, a read and a check per entry, until one fits, then writes it back or
// removes it by shifting later entries down (a read and a write per entry moved). A
// free scans to its place the same way, then merges or shifts later entries up. The
// extents in use in a heap are at most MAX_EXTENTS. Last, the result is handed to the
// output register; that step waits while the previous result still sits unaccepted
// in the output register. A new item is taken while the previous result still waits
// on the output. Writing a heap size resets that heap at once.
`default_nettype none
`include "first_fit_range_allocator_macros.svh"
module first_fit_range_allocator #(
    parameter int MAX_EXTENTS = ffra_pkg::MAX_EXTENTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_addr,
    input  wire logic [ffra_pkg::CNT_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       func,
    input  wire logic                       heap,
    input  wire logic [ffra_pkg::OFF_W-1:0] range_offset,
    input  wire logic [ffra_pkg::CNT_W-1:0] range_count,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [2:0]                      status,
    output logic [ffra_pkg::OFF_W-1:0]      granted_offset,
    output logic [ffra_pkg::CNT_W-1:0]      granted_count
);
    import ffra_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    ffra_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Extent table and result register.
    ffra_datapath #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .func           (func),
        .heap           (heap),
        .range_offset   (range_offset),
        .range_count    (range_count),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .status         (status),
        .granted_offset (granted_offset),
        .granted_count  (granted_count)
    );

    // Checks on the sequencing and the results.
    `FFRA_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
    `FFRA_NEVER(a_rd_wr, cmd.rd && cmd.wr, "extent memory read and written in one cycle")
    `FFRA_ASSERT(a_grant_ok, (out_valid && (|granted_count)) |-> (status == ST_OK), "bad grant")
    `FFRA_NEVER(a_cnt_both, cmd.n_inc && cmd.n_dec, "extent count raised and lowered together")
endmodule
`default_nettype wire

>>> test/first_fit_range_allocator_test.sv
// Self-checking testbench for the first-fit range allocator.
// Depends on ffra_pkg and the first_fit_range_allocator top level; nothing else.
`timescale 1ns / 1ps

module first_fit_range_allocator_test;
    import ffra_pkg::*;

    localparam int NUM_EXTENTS = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_WAIT = 100;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam bit FN_ALLOC = 1'b0;
    localparam bit FN_FREE = 1'b1;
    localparam bit HEAP_TARGET = 1'b0;
    localparam bit HEAP_VIEW = 1'b1;

    typedef struct packed {
        status_t          st;
        logic [OFF_W-1:0] off;
        logic [CNT_W-1:0] cnt;
    } grant_t;

    typedef struct packed {
        bit               hp;
        logic [OFF_W-1:0] off;
        logic [CNT_W-1:0] cnt;
    } range_t;

    // Tracks the free-extent tables of both heaps and the grants still due.
    class alloc_scoreboard;
        logic [OFF_W-1:0] ext_start [2][NUM_EXTENTS];
        logic [CNT_W-1:0] ext_len [2][NUM_EXTENTS];
        int      ext_used [2];
        grant_t  grants_due [$];
        range_t  held [$];
        int      failures;
        int      reported;

        function new();
            failures = 0;
            reported = 0;
            set_size(HEAP_TARGET, TARGET_RESET);
            set_size(HEAP_VIEW, VIEW_RESET);
        endfunction

        // A size write reinitializes the heap; anything held from it is dropped.
        function void set_size(bit hp, logic [CNT_W-1:0] size);
            logic [CNT_W-1:0] sz;
            sz = (size > CNT_W'(SLOT_LIMIT)) ? CNT_W'(SLOT_LIMIT) : size;
            for (int i = 0; i < NUM_EXTENTS; i++)
            begin
                ext_start[hp][i] = '0;
                ext_len[hp][i] = '0;
            end
            ext_len[hp][0] = sz;
            ext_used[hp] = (sz != 0) ? 1 : 0;
            for (int i = held.size() - 1; i >= 0; i--)
            begin
                if (held[i].hp == hp)
                    held.delete(i);
            end
        endfunction

        function void drop_entry(bit hp, int pos);
            for (int i = pos; i + 1 < ext_used[hp]; i++)
            begin
                ext_start[hp][i] = ext_start[hp][i + 1];
                ext_len[hp][i] = ext_len[hp][i + 1];
            end
            ext_start[hp][ext_used[hp] - 1] = '0;
            ext_len[hp][ext_used[hp] - 1] = '0;
            ext_used[hp]--;
        endfunction

        function status_t release_range(bit hp, logic [OFF_W-1:0] off,
                                        logic [CNT_W-1:0] cnt);
            logic [SUM_W-1:0] stop;
            logic [SUM_W-1:0] left_end;
            int pos;
            bit has_l, has_r, join_l, join_r;
            stop = SUM_W'(off) + SUM_W'(cnt);
            if (stop > SLOT_LIMIT)
                return ST_DOUBLE;
            pos = 0;
            while (pos < ext_used[hp] && ext_start[hp][pos] <= off)
                pos++;
            has_l = pos > 0;
            has_r = pos < ext_used[hp];
            left_end = has_l ? SUM_W'(ext_start[hp][pos - 1]) + SUM_W'(ext_len[hp][pos - 1])
                             : '0;
            if (has_l && left_end > SUM_W'(off))
                return ST_DOUBLE;
            if (has_r && stop > SUM_W'(ext_start[hp][pos]))
                return ST_DOUBLE;
            join_l = has_l && left_end == SUM_W'(off);
            join_r = has_r && stop == SUM_W'(ext_start[hp][pos]);
            if (join_l && join_r)
            begin
                ext_len[hp][pos - 1] += cnt + ext_len[hp][pos];
                drop_entry(hp, pos);
            end
            else if (join_l)
                ext_len[hp][pos - 1] += cnt;
            else if (join_r)
            begin
                ext_start[hp][pos] = off;
                ext_len[hp][pos] += cnt;
            end
            else
            begin
                if (ext_used[hp] >= NUM_EXTENTS)
                    return ST_FULL;
                for (int i = ext_used[hp]; i > pos; i--)
                begin
                    ext_start[hp][i] = ext_start[hp][i - 1];
                    ext_len[hp][i] = ext_len[hp][i - 1];
                end
                ext_start[hp][pos] = off;
                ext_len[hp][pos] = cnt;
                ext_used[hp]++;
            end
            return ST_OK;
        endfunction

        // Works out the grant for an accepted item and updates the tables.
        function void note_item(bit fn, bit hp, logic [OFF_W-1:0] off,
                                logic [CNT_W-1:0] cnt);
            grant_t g;
            range_t r;
            g = '{st: ST_NOFIT, off: '0, cnt: '0};
            if (cnt == 0)
                g.st = ST_ZERO;
            else if (fn == FN_FREE)
                g.st = release_range(hp, off, cnt);
            else
            begin
                for (int i = 0; i < ext_used[hp]; i++)
                begin
                    if (ext_len[hp][i] >= cnt)
                    begin
                        g = '{st: ST_OK, off: ext_start[hp][i], cnt: cnt};
                        ext_start[hp][i] += OFF_W'(cnt);
                        ext_len[hp][i] -= cnt;
                        if (ext_len[hp][i] == 0)
                            drop_entry(hp, i);
                        break;
                    end
                end
                if (g.st == ST_OK)
                begin
                    r = '{hp: hp, off: g.off, cnt: cnt};
                    held.push_back(r);
                end
            end
            grants_due.push_back(g);
        endfunction

        function void check_result(logic [2:0] st, logic [OFF_W-1:0] off,
                                   logic [CNT_W-1:0] cnt);
            grant_t g;
            if (grants_due.size() == 0)
            begin
                failures++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result: status %0d offset %0d count %0d",
                             st, off, cnt);
                end
                return;
            end
            g = grants_due.pop_front();
            if (st !== g.st || off !== g.off || cnt !== g.cnt)
            begin
                failures++;
                if (reported < 10)
                begin
                    reported++;
                    $display("mismatch: expected status %0d offset %0d count %0d, got %0d %0d %0d",
                             g.st, g.off, g.cnt, st, off, cnt);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [1:0]       cfg_addr;
    logic [CNT_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    logic             func;
    logic             heap;
    logic [OFF_W-1:0] range_offset;
    logic [CNT_W-1:0] range_count;
    logic             out_valid;
    logic             out_ready;
    logic [2:0]       status;
    logic [OFF_W-1:0] granted_offset;
    logic [CNT_W-1:0] granted_count;

    alloc_scoreboard sb;
    int cycles;
    int stall_mode;

    first_fit_range_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .heap(heap), .range_offset(range_offset), .range_count(range_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .granted_offset(granted_offset), .granted_count(granted_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run ends here if the block stops answering.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("first_fit_range_allocator_test NOT OK");
            $finish;
        end
    end

    // Every result taken by the receiver is checked against the oldest grant due.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, granted_offset, granted_count);
    end

    // Receiver stalls: always ready, light random stalls, or long stalls.
    always @(negedge clk)
    begin
        if (stall_mode == 0)
            out_ready <= 1'b1;
        else if (stall_mode == 1)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= ($urandom_range(0, 9) == 0);
    end

    // Presents one item and holds it until the block accepts it.
    task automatic send_item(bit fn, bit hp, logic [OFF_W-1:0] off, logic [CNT_W-1:0] cnt);
        @(negedge clk);
        in_valid = 1'b1;
        func = fn;
        heap = hp;
        range_offset = off;
        range_count = cnt;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(fn, hp, off, cnt);
    endtask

    task automatic pause_sender(int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            func = 1'($urandom_range(0, 1));
            range_offset = OFF_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Waits until every grant is in and the block is idle, then writes a register.
    task automatic write_size(logic [1:0] idx, logic [CNT_W-1:0] value);
        pause_sender(1);
        while (sb.grants_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(posedge clk);
        if (idx == CFG_TARGET)
            sb.set_size(HEAP_TARGET, value);
        else if (idx == CFG_VIEW)
            sb.set_size(HEAP_VIEW, value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // One random item: mostly allocations and frees of held ranges, some noise.
    task automatic random_item(int big_pct);
        int pick;
        int idx;
        range_t r;
        logic [CNT_W-1:0] part;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 99) < big_pct)
                send_item(FN_ALLOC, 1'($urandom_range(0, 1)), OFF_W'($urandom),
                          CNT_W'($urandom_range(1, 2097151)));
            else
                send_item(FN_ALLOC, 1'($urandom_range(0, 1)), OFF_W'($urandom),
                          CNT_W'($urandom_range(1, 48)));
        end
        else if (pick < 85 && sb.held.size() != 0)
        begin
            // Free a held range whole or its low part, keeping the rest held.
            idx = $urandom_range(0, sb.held.size() - 1);
            r = sb.held[idx];
            part = ($urandom_range(0, 2) == 0) ? CNT_W'($urandom_range(1, r.cnt)) : r.cnt;
            if (part == r.cnt)
                sb.held.delete(idx);
            else
            begin
                sb.held[idx].off = r.off + OFF_W'(part);
                sb.held[idx].cnt = r.cnt - part;
            end
            send_item(FN_FREE, r.hp, r.off, part);
        end
        else if (pick < 92)
            send_item(FN_FREE, 1'($urandom_range(0, 1)), OFF_W'($urandom),
                      CNT_W'($urandom_range(0, 2097151)));
        else if (pick < 96)
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), OFF_W'($urandom),
                      '0);
        else
            send_item(FN_FREE, 1'($urandom_range(0, 1)), OFF_W'($urandom_range(0, 2000)),
                      CNT_W'($urandom_range(1, 8)));
    endtask

    task automatic random_phase(int items, int big_pct);
        int burst;
        burst = 0;
        for (int i = 0; i < items; i++)
        begin
            if (burst == 0)
            begin
                pause_sender($urandom_range(0, 1) ? $urandom_range(1, 12) : 0);
                burst = $urandom_range(1, 20);
            end
            burst--;
            random_item(big_pct);
        end
    endtask

    initial
    begin
        logic [CNT_W-1:0] target_sizes [6];
        logic [CNT_W-1:0] view_sizes [6];
        sb = new();
        cycles = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        func = 1'b0;
        heap = 1'b0;
        range_offset = '0;
        range_count = '0;
        out_ready = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero counts, exhausting a heap, overlaps, the slot space edge.
        send_item(FN_ALLOC, HEAP_TARGET, '1, '0);
        send_item(FN_FREE, HEAP_VIEW, '1, '0);
        send_item(FN_ALLOC, HEAP_TARGET, '0, 21'd1024);
        send_item(FN_ALLOC, HEAP_TARGET, '0, 21'd1);
        send_item(FN_FREE, HEAP_TARGET, '0, 21'd1024);
        send_item(FN_FREE, HEAP_TARGET, 20'd512, 21'd1);
        send_item(FN_FREE, HEAP_VIEW, '1, 21'd2);
        send_item(FN_FREE, HEAP_VIEW, 20'hFFFFE, 21'd1);
        send_item(FN_FREE, HEAP_VIEW, '1, 21'd1);
        send_item(FN_FREE, HEAP_VIEW, 20'd70000, 21'd100);
        send_item(FN_ALLOC, HEAP_VIEW, '0, 21'd1048576);
        send_item(FN_ALLOC, HEAP_VIEW, '0, 21'h1FFFFF);
        send_item(FN_ALLOC, HEAP_VIEW, '0, 21'd65536);
        stall_mode = 2;
        send_item(FN_ALLOC, HEAP_VIEW, '0, 21'd3);

        // Whole slot space in one heap, then a saturated and an empty size.
        write_size(CFG_TARGET, 21'd1048576);
        send_item(FN_ALLOC, HEAP_TARGET, '0, 21'd1048576);
        send_item(FN_FREE, HEAP_TARGET, '0, 21'd1048576);
        write_size(CFG_VIEW, 21'h1FFFFF);
        send_item(FN_ALLOC, HEAP_VIEW, '0, 21'd1048576);
        write_size(CFG_VIEW, '0);
        send_item(FN_ALLOC, HEAP_VIEW, '0, 21'd1);
        send_item(FN_FREE, HEAP_VIEW, 20'd10, 21'd5);
        write_size(CFG_SPARE_A, 21'd7);
        write_size(CFG_SPARE_B, 21'h1FFFFF);
        send_item(FN_ALLOC, HEAP_TARGET, '0, 21'd1);

        // Fill the extent table of one heap, then ask for one more entry.
        stall_mode = 1;
        write_size(CFG_TARGET, 21'd64);
        send_item(FN_ALLOC, HEAP_TARGET, '0, 21'd64);
        for (int i = 0; i < 64; i += 2)
            send_item(FN_FREE, HEAP_TARGET, OFF_W'(i), 21'd1);
        send_item(FN_FREE, HEAP_TARGET, 20'd100, 21'd1);
        send_item(FN_FREE, HEAP_TARGET, 20'd63, 21'd1);
        send_item(FN_FREE, HEAP_TARGET, 20'd1, 21'd1);
        send_item(FN_FREE, HEAP_TARGET, 20'd100, 21'd1);

        // Random phases over a range of heap sizes and stall patterns.
        target_sizes = '{21'd64, 21'd1048576, 21'd0, 21'd1000, 21'd200, 21'd1024};
        view_sizes = '{21'd300, 21'h1FFFFF, 21'd128, 21'd1, 21'd5000, 21'd65536};
        for (int p = 0; p < 6; p++)
        begin
            stall_mode = p % 3;
            write_size(CFG_TARGET, target_sizes[p]);
            write_size(CFG_VIEW, view_sizes[p]);
            random_phase(100, (p == 1) ? 30 : 3);
        end

        pause_sender(1);
        while (sb.grants_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        if (sb.failures == 0)
            $display("first_fit_range_allocator_test OK");
        else
            $display("first_fit_range_allocator_test NOT OK");
        $finish;
    end
endmodule
